// ===== hw/rtl/sph_cubic_spline_kernel_grad_defines.svh =====
// Assertion macros shared by the checker of the SPH kernel gradient block.
`ifndef SPH_CUBIC_SPLINE_KERNEL_GRAD_DEFINES_SVH
`define SPH_CUBIC_SPLINE_KERNEL_GRAD_DEFINES_SVH
// Same-cycle implication.
`define SPHK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphk assertion failed");
// Next-cycle implication.
`define SPHK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphk assertion failed");
`endif

// ===== hw/rtl/sphk_pkg.sv =====
// Package with the types and constants of the SPH kernel gradient block.
`default_nettype none
package sphk_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int IN_W       = 32;
   localparam int OUT_W      = 48;
   localparam int CFG_H_W    = 32;
   localparam int DIST_W     = 32;
   localparam int SUMSQ_W    = 64;
   localparam int PROD_Q_W   = DIST_W + CFG_H_W;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int A_W        = FRAC_BITS + 2;
   localparam int A2_W       = FRAC_BITS + 3;
   localparam int A3_W       = FRAC_BITS + 4;
   localparam int B_W        = FRAC_BITS + 1;
   localparam int S_W        = FRAC_BITS + 4;
   localparam int SS_W       = S_W + 1;
   localparam int U_W        = FRAC_BITS + 1;
   localparam int REM_W      = IN_W + FRAC_BITS;
   localparam int M_W        = S_W;
   localparam int T_W        = M_W + CFG_H_W - FRAC_BITS;
   localparam int GS_LO_W    = OUT_W / 2;
   localparam int GS_HI_W    = OUT_W - GS_LO_W;
   localparam int ROOT_STEPS = DIST_W;
   localparam int DIV_STEPS  = U_W;
   localparam int ONE_FIX    = 1 << FRAC_BITS;
   localparam int TWO_FIX    = 1 << (FRAC_BITS + 1);
   localparam int K_CUBE_B   = 4;
   localparam int K_SLOPE_A  = 3;
   localparam int K_SLOPE_B  = 12;

   localparam logic [CFG_H_W-1:0] INV_H_RESET       = 32'h0001_0000;
   localparam logic [OUT_W-1:0]   VALUE_SCALE_RESET = 48'd5215;
   localparam logic [OUT_W-1:0]   GRAD_SCALE_RESET  = 48'd5215;
   localparam logic [OUT_W-1:0]   POS_LIM = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic [OUT_W-1:0]   NEG_LIM = {1'b1, {(OUT_W - 1){1'b0}}};

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_H       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_SCALE  = 2'd2;

   typedef struct packed {
      logic signed [IN_W-1:0] offset_x;
      logic signed [IN_W-1:0] offset_y;
      logic signed [IN_W-1:0] offset_z;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]        kernel_value;
      logic signed [OUT_W-1:0] grad_x;
      logic signed [OUT_W-1:0] grad_y;
      logic signed [OUT_W-1:0] grad_z;
      logic                    zero_distance;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [CFG_H_W-1:0] inv_h;
      logic [OUT_W-1:0]   value_scale;
      logic [OUT_W-1:0]   gradient_scale;
   } cfg_type;

   typedef struct packed {
      logic [2:0][IN_W-1:0] mag;
      logic [2:0]           neg;
      logic [DIST_W-1:0]    norm;
   } root_type;

   typedef struct packed {
      logic [2:0][IN_W-1:0] mag;
      logic [2:0]           neg;
      logic [DIST_W-1:0]    norm;
      logic                 zero;
      logic [OUT_W-1:0]     kval;
      logic                 ksat;
      logic                 sneg;
      logic [S_W-1:0]       smag;
   } shape_type;

   typedef struct packed {
      logic [2:0][U_W-1:0] u;
      logic [2:0]          neg;
      logic                zero;
      logic [OUT_W-1:0]    kval;
      logic                ksat;
      logic                sneg;
      logic [S_W-1:0]      smag;
   } div_type;
endpackage
`default_nettype wire

// ===== hw/rtl/sphk_root.sv =====
// Component magnitudes, sum of squares and a pipelined integer square root.
`default_nettype none
module sphk_root
   import sphk_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output root_type out_data
);
   logic [2:0][IN_W-1:0]    off_w;
   logic [2:0][IN_W-1:0]    mag_in;
   logic [2:0]              neg_in;
   logic                    va_ff;
   logic [2:0][IN_W-1:0]    mag_a_ff;
   logic                    vb_ff;
   logic [2:0]              neg_a_ff;
   logic [2:0][SUMSQ_W-1:0] sq_b_ff;
   logic [2:0][IN_W-1:0]    mag_b_ff;
   logic [2:0]              neg_b_ff;
   logic                    v_ff    [ROOT_STEPS+1];
   logic [SUMSQ_W-1:0]      x_ff    [ROOT_STEPS+1];
   logic [SUMSQ_W-1:0]      r_ff    [ROOT_STEPS+1];
   logic [2:0][IN_W-1:0]    mag_ff  [ROOT_STEPS+1];
   logic [2:0]              neg_ff  [ROOT_STEPS+1];
   logic [SUMSQ_W-1:0]      bit_w   [ROOT_STEPS];
   logic [SUMSQ_W-1:0]      trial_w [ROOT_STEPS];
   logic [SUMSQ_W-1:0]      x_in    [ROOT_STEPS];
   logic [SUMSQ_W-1:0]      r_in    [ROOT_STEPS];

   assign off_w = {in_data.offset_z, in_data.offset_y, in_data.offset_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = off_w[i][IN_W-1];
         mag_in[i] = off_w[i][IN_W-1] ? (~off_w[i] + 1'b1) : off_w[i];
      end
   end

   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bit_w[k]   = SUMSQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
         trial_w[k] = r_ff[k] + bit_w[k];
         if (x_ff[k] >= trial_w[k]) begin
            x_in[k] = x_ff[k] - trial_w[k];
            r_in[k] = (r_ff[k] >> 1) + bit_w[k];
         end else begin
            x_in[k] = x_ff[k];
            r_in[k] = r_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int k = 0; k <= ROOT_STEPS; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         va_ff   <= in_valid;
         vb_ff   <= va_ff;
         v_ff[0] <= vb_ff;
         for (int k = 0; k < ROOT_STEPS; k++) v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= mag_in;
         neg_a_ff <= neg_in;
         for (int i = 0; i < 3; i++) begin
            sq_b_ff[i] <= SUMSQ_W'(mag_a_ff[i]) * SUMSQ_W'(mag_a_ff[i]);
         end
         mag_b_ff  <= mag_a_ff;
         neg_b_ff  <= neg_a_ff;
         x_ff[0]   <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
         r_ff[0]   <= '0;
         mag_ff[0] <= mag_b_ff;
         neg_ff[0] <= neg_b_ff;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            x_ff[k+1]   <= x_in[k];
            r_ff[k+1]   <= r_in[k];
            mag_ff[k+1] <= mag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign out_valid     = v_ff[ROOT_STEPS];
   assign out_data.mag  = mag_ff[ROOT_STEPS];
   assign out_data.neg  = neg_ff[ROOT_STEPS];
   assign out_data.norm = r_ff[ROOT_STEPS][DIST_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/sphk_shape.sv =====
// Normalised distance, spline polynomials, kernel value and derivative scalar.
`default_nettype none
module sphk_shape
   import sphk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [CFG_H_W-1:0] inv_h,
   input  logic [OUT_W-1:0]   value_scale,
   input  logic               in_valid,
   input  root_type           in_data,
   output logic               out_valid,
   output shape_type          out_data
);
   localparam int AA_W  = 2 * A_W;
   localparam int BB_W  = 2 * B_W;
   localparam int AAA_W = A2_W + A_W;
   localparam int BBB_W = 2 * B_W;
   localparam int PW    = A3_W + 2;
   localparam int KP_W  = OUT_W + A3_W;

   logic [PROD_Q_W-1:0] prod_q_w;
   logic [A_W-1:0]      a_w;
   logic [B_W-1:0]      b_w;
   logic [AA_W-1:0]     aa_w;
   logic [BB_W-1:0]     bb_w;
   logic [AAA_W-1:0]    aaa_w;
   logic [BBB_W-1:0]    bbb_w;
   logic [SS_W-1:0]     sa_w;
   logic [SS_W-1:0]     sb_w;
   logic [SS_W-1:0]     s_in;
   logic [PW-1:0]       poly_w;
   logic [A3_W-1:0]     poly_in;
   logic [KP_W-1:0]     kp_w;

   logic            v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   root_type        rt1_ff, rt2_ff, rt3_ff, rt4_ff, rt5_ff;
   logic            zero1_ff, zero2_ff, zero3_ff, zero4_ff, zero5_ff;
   logic            qone1_ff, qone2_ff, qone3_ff;
   logic            qtwo1_ff, qtwo2_ff, qtwo3_ff;
   logic [Q_W-1:0]  ql1_ff;
   logic [A_W-1:0]  a2s_a_ff;
   logic [B_W-1:0]  a2s_b_ff;
   logic [A2_W-1:0] a2_ff;
   logic [B_W-1:0]  b2_ff;
   logic [A3_W-1:0] a3_ff;
   logic [B_W-1:0]  b3_ff;
   logic [SS_W-1:0] s3_ff;
   logic [A3_W-1:0] poly4_ff;
   logic            sneg4_ff, sneg5_ff;
   logic [S_W-1:0]  smag4_ff, smag5_ff;
   logic [OUT_W-1:0] kval5_ff;
   logic            ksat5_ff;

   always_comb begin
      prod_q_w = PROD_Q_W'(in_data.norm) * PROD_Q_W'(inv_h);
      a_w      = A_W'(TWO_FIX) - A_W'(ql1_ff);
      b_w      = B_W'(ONE_FIX) - ql1_ff;
      aa_w     = AA_W'(a_w) * AA_W'(a_w);
      bb_w     = BB_W'(b_w) * BB_W'(b_w);
      aaa_w    = AAA_W'(a2_ff) * AAA_W'(a2s_a_ff);
      bbb_w    = BBB_W'(b2_ff) * BBB_W'(a2s_b_ff);
      sb_w     = SS_W'(b2_ff) * SS_W'(K_SLOPE_B);
      sa_w     = SS_W'(a2_ff) * SS_W'(K_SLOPE_A);
      if (qone2_ff) begin
         s_in = sb_w - sa_w;
      end else if (qtwo2_ff) begin
         s_in = SS_W'(0) - sa_w;
      end else begin
         s_in = '0;
      end
      poly_w = PW'(a3_ff) - PW'(b3_ff) * PW'(K_CUBE_B);
      if (qone3_ff) begin
         poly_in = poly_w[PW-1] ? '0 : A3_W'(poly_w);
      end else if (qtwo3_ff) begin
         poly_in = a3_ff;
      end else begin
         poly_in = '0;
      end
      kp_w = KP_W'(value_scale) * KP_W'(poly4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt1_ff   <= in_data;
         zero1_ff <= (in_data.norm == '0);
         qtwo1_ff <= (prod_q_w[PROD_Q_W-1:FRAC_BITS+Q_W] == '0);
         qone1_ff <= (prod_q_w[PROD_Q_W-1:FRAC_BITS+Q_W-1] == '0);
         ql1_ff   <= prod_q_w[FRAC_BITS+Q_W-1:FRAC_BITS];

         rt2_ff   <= rt1_ff;
         zero2_ff <= zero1_ff;
         qone2_ff <= qone1_ff;
         qtwo2_ff <= qtwo1_ff;
         a2s_a_ff <= a_w;
         a2s_b_ff <= b_w;
         a2_ff    <= aa_w[FRAC_BITS+A2_W-1:FRAC_BITS];
         b2_ff    <= bb_w[FRAC_BITS+B_W-1:FRAC_BITS];

         rt3_ff   <= rt2_ff;
         zero3_ff <= zero2_ff;
         qone3_ff <= qone2_ff;
         qtwo3_ff <= qtwo2_ff;
         a3_ff    <= aaa_w[FRAC_BITS+A3_W-1:FRAC_BITS];
         b3_ff    <= bbb_w[FRAC_BITS+B_W-1:FRAC_BITS];
         s3_ff    <= s_in;

         rt4_ff   <= rt3_ff;
         zero4_ff <= zero3_ff;
         poly4_ff <= poly_in;
         sneg4_ff <= s3_ff[SS_W-1];
         smag4_ff <= s3_ff[SS_W-1] ? S_W'(~s3_ff + 1'b1) : S_W'(s3_ff);

         rt5_ff   <= rt4_ff;
         zero5_ff <= zero4_ff;
         sneg5_ff <= sneg4_ff;
         smag5_ff <= smag4_ff;
         ksat5_ff <= (kp_w[KP_W-1:FRAC_BITS+OUT_W] != '0);
         kval5_ff <= (kp_w[KP_W-1:FRAC_BITS+OUT_W] != '0) ? '1 :
                     kp_w[FRAC_BITS+OUT_W-1:FRAC_BITS];
      end
   end

   assign out_valid     = v5_ff;
   assign out_data.mag  = rt5_ff.mag;
   assign out_data.neg  = rt5_ff.neg;
   assign out_data.norm = rt5_ff.norm;
   assign out_data.zero = zero5_ff;
   assign out_data.kval = kval5_ff;
   assign out_data.ksat = ksat5_ff;
   assign out_data.sneg = sneg5_ff;
   assign out_data.smag = smag5_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sphk_divide.sv =====
// Pipelined restoring divider giving each component's share of the distance.
`default_nettype none
module sphk_divide
   import sphk_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  shape_type in_data,
   output logic      out_valid,
   output div_type   out_data
);
   logic                  v_ff   [DIV_STEPS];
   shape_type             sh_ff  [DIV_STEPS];
   logic [2:0][REM_W-1:0] rem_ff [DIV_STEPS];
   logic [2:0][U_W-1:0]   quo_ff [DIV_STEPS];
   logic                  v_in   [DIV_STEPS];
   shape_type             sh_in  [DIV_STEPS];
   logic [2:0][REM_W-1:0] rem_in [DIV_STEPS];
   logic [2:0][U_W-1:0]   quo_in [DIV_STEPS];
   logic [REM_W-1:0]      src_rem;
   logic [U_W-1:0]        src_quo;
   logic [REM_W-1:0]      dsh;

   always_comb begin
      src_rem = '0;
      src_quo = '0;
      dsh     = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         v_in[k]  = (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         sh_in[k] = (k == 0) ? in_data : sh_ff[(k == 0) ? 0 : k - 1];
         dsh      = REM_W'(sh_in[k].norm) << (DIV_STEPS - 1 - k);
         for (int l = 0; l < 3; l++) begin
            if (k == 0) begin
               src_rem = {sh_in[k].mag[l], {FRAC_BITS{1'b0}}};
               src_quo = '0;
            end else begin
               src_rem = rem_ff[(k == 0) ? 0 : k - 1][l];
               src_quo = quo_ff[(k == 0) ? 0 : k - 1][l];
            end
            if (src_rem >= dsh) begin
               rem_in[k][l] = src_rem - dsh;
               quo_in[k][l] = {src_quo[U_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = src_rem;
               quo_in[k][l] = {src_quo[U_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) v_ff[k] <= v_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            sh_ff[k]  <= sh_in[k];
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid     = v_ff[DIV_STEPS-1];
   assign out_data.u    = quo_ff[DIV_STEPS-1];
   assign out_data.neg  = sh_ff[DIV_STEPS-1].neg;
   assign out_data.zero = sh_ff[DIV_STEPS-1].zero;
   assign out_data.kval = sh_ff[DIV_STEPS-1].kval;
   assign out_data.ksat = sh_ff[DIV_STEPS-1].ksat;
   assign out_data.sneg = sh_ff[DIV_STEPS-1].sneg;
   assign out_data.smag = sh_ff[DIV_STEPS-1].smag;
endmodule
`default_nettype wire

// ===== hw/rtl/sphk_grad.sv =====
// Gradient scaling chain with saturation and the result register.
`default_nettype none
module sphk_grad
   import sphk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [CFG_H_W-1:0] inv_h,
   input  logic [OUT_W-1:0]   gradient_scale,
   input  logic               in_valid,
   input  div_type            in_data,
   output logic               out_valid,
   output rsp_type            out_data
);
   localparam int MU_W = S_W + U_W;
   localparam int MT_W = M_W + CFG_H_W;
   localparam int PL_W = T_W + GS_LO_W;
   localparam int PH_W = T_W + GS_HI_W;
   localparam int P_W  = T_W + OUT_W;
   localparam int RW   = P_W - FRAC_BITS;

   logic [2:0][MU_W-1:0]  mu_w;
   logic [2:0][MT_W-1:0]  mt_w;
   logic [2:0][P_W-1:0]   p_w;
   logic [2:0][RW-1:0]    r_w;
   logic [2:0][OUT_W-1:0] lim_w;
   logic [2:0]            gneg_w;
   logic [2:0]            over_w;
   logic [2:0][OUT_W-1:0] g_in;
   logic [2:0][OUT_W-1:0] grad_in;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                  gate1_ff, gate2_ff, gate3_ff;
   logic [2:0]            gneg1_ff, gneg2_ff, gneg3_ff, gneg4_ff;
   logic                  zero1_ff, zero2_ff, zero3_ff, zero4_ff;
   logic [OUT_W-1:0]      kval1_ff, kval2_ff, kval3_ff, kval4_ff;
   logic                  ksat1_ff, ksat2_ff, ksat3_ff, ksat4_ff;
   logic [2:0][M_W-1:0]   m1_ff;
   logic [2:0][T_W-1:0]   t2_ff;
   logic [2:0][PL_W-1:0]  plo3_ff;
   logic [2:0][PH_W-1:0]  phi3_ff;
   logic [2:0][OUT_W-1:0] g4_ff;
   logic [2:0]            gsat4_ff;
   rsp_type               rsp_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mu_w[l]    = MU_W'(in_data.smag) * MU_W'(in_data.u[l]);
         mt_w[l]    = MT_W'(m1_ff[l]) * MT_W'(inv_h);
         p_w[l]     = {phi3_ff[l], {GS_LO_W{1'b0}}} + P_W'(plo3_ff[l]);
         r_w[l]     = p_w[l][P_W-1:FRAC_BITS];
         gneg_w[l]  = gneg3_ff[l];
         lim_w[l]   = gneg_w[l] ? NEG_LIM : POS_LIM;
         over_w[l]  = r_w[l] > RW'(lim_w[l]);
         if (!gate3_ff) begin
            g_in[l] = '0;
         end else if (over_w[l]) begin
            g_in[l] = lim_w[l];
         end else begin
            g_in[l] = r_w[l][OUT_W-1:0];
         end
         grad_in[l] = gneg4_ff[l] ? (~g4_ff[l] + 1'b1) : g4_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gate1_ff <= !in_data.zero && (in_data.smag != '0);
         gneg1_ff <= in_data.neg ^ {3{in_data.sneg}};
         zero1_ff <= in_data.zero;
         kval1_ff <= in_data.kval;
         ksat1_ff <= in_data.ksat;
         for (int l = 0; l < 3; l++) begin
            m1_ff[l]   <= mu_w[l][FRAC_BITS+M_W-1:FRAC_BITS];
            t2_ff[l]   <= mt_w[l][MT_W-1:FRAC_BITS];
            plo3_ff[l] <= PL_W'(t2_ff[l]) * PL_W'(gradient_scale[GS_LO_W-1:0]);
            phi3_ff[l] <= PH_W'(t2_ff[l]) * PH_W'(gradient_scale[OUT_W-1:GS_LO_W]);
            g4_ff[l]   <= g_in[l];
            gsat4_ff[l] <= gate3_ff && over_w[l];
         end
         gate2_ff <= gate1_ff;
         gneg2_ff <= gneg1_ff;
         zero2_ff <= zero1_ff;
         kval2_ff <= kval1_ff;
         ksat2_ff <= ksat1_ff;
         gate3_ff <= gate2_ff;
         gneg3_ff <= gneg2_ff;
         zero3_ff <= zero2_ff;
         kval3_ff <= kval2_ff;
         ksat3_ff <= ksat2_ff;
         gneg4_ff <= gneg3_ff;
         zero4_ff <= zero3_ff;
         kval4_ff <= kval3_ff;
         ksat4_ff <= ksat3_ff;
         rsp_ff.kernel_value  <= kval4_ff;
         rsp_ff.grad_x        <= grad_in[0];
         rsp_ff.grad_y        <= grad_in[1];
         rsp_ff.grad_z        <= grad_in[2];
         rsp_ff.zero_distance <= zero4_ff;
         rsp_ff.saturated     <= ksat4_ff || (gsat4_ff != '0);
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sph_cubic_spline_kernel_grad.sv =====
// Top level of the 3D cubic spline SPH kernel value and gradient pipeline.
//
//   Port group  Direction  Carries
//   req_        in         one offset vector per item
//   rsp_        out        kernel value, gradient, zero-distance and clip flags
//   csr_        in         register index and write data, always ready
//
// One item enters per cycle while req_ready is high; each item passes through the
// root, shape, divide and grad stages to the result register. The 32-step square
// root and the 17-step divider take one step per stage. When a result waits, every
// stage holds and req_ready falls; nothing is lost. Reset clears the valid bits and
// sets the registers to their defaults.
`default_nettype none
module sph_cubic_spline_kernel_grad
   import sphk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [OUT_W-1:0]     csr_data
);
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      en;
   logic      root_valid;
   root_type  root_data;
   logic      shape_valid;
   shape_type shape_data;
   logic      div_valid;
   div_type   div_data;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INV_H:       cfg_in.inv_h          = csr_data[CFG_H_W-1:0];
            CSR_VALUE_SCALE: cfg_in.value_scale    = csr_data;
            CSR_GRAD_SCALE:  cfg_in.gradient_scale = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_h          <= INV_H_RESET;
         cfg_ff.value_scale    <= VALUE_SCALE_RESET;
         cfg_ff.gradient_scale <= GRAD_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sphk_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   sphk_shape u_shape (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .inv_h       (cfg_ff.inv_h),
      .value_scale (cfg_ff.value_scale),
      .in_valid    (root_valid),
      .in_data     (root_data),
      .out_valid   (shape_valid),
      .out_data    (shape_data)
   );

   sphk_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (shape_valid),
      .in_data   (shape_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   sphk_grad u_grad (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .inv_h          (cfg_ff.inv_h),
      .gradient_scale (cfg_ff.gradient_scale),
      .in_valid       (div_valid),
      .in_data        (div_data),
      .out_valid      (rsp_valid),
      .out_data       (rsp_data)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/sphk_checker.sv =====
// Port-level assertions for the SPH kernel gradient block and their binding.
`default_nettype none
`include "sph_cubic_spline_kernel_grad_defines.svh"
module sphk_checker
   import sphk_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `SPHK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SPHK_ASSERT_NOW(a_zero_grad, clock, reset, rsp_valid && rsp_data.zero_distance, (rsp_data.grad_x == '0) && (rsp_data.grad_y == '0) && (rsp_data.grad_z == '0))
   `SPHK_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid || rsp_ready, req_ready)
   `SPHK_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
endmodule

bind sph_cubic_spline_kernel_grad sphk_checker u_sphk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== tb/tb_sph_cubic_spline_kernel_grad.sv =====
// Self-checking testbench for the 3D cubic spline SPH kernel value and gradient block.
`default_nettype none
module tb_sph_cubic_spline_kernel_grad;
   import sphk_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD = 200;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [OUT_W-1:0] csr_data = '0;

   logic [31:0] inv_h_reg;
   logic [47:0] value_scale_reg;
   logic [47:0] grad_scale_reg;

   rsp_type kernel_results_due[$];
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int zero_seen = 0;
   int sat_seen = 0;
   int cycles = 0;
   bit noisy = 1'b1;
   bit hold_request = 1'b0;

   sph_cubic_spline_kernel_grad dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run exceeded its cycle limit with %0d results pending.",
                  kernel_results_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] mul_frac_clip(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] lim, inout bit sat);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
      if (p > {64'd0, lim}) begin
         sat = 1'b1;
         return lim;
      end
      return p[63:0];
   endfunction

   function automatic rsp_type kernel_of_offset(input req_type r);
      rsp_type o;
      logic [31:0] comp [3];
      logic [63:0] mag [3];
      bit neg [3];
      logic [63:0] sumsq, norm, q, a, b, a2, a3, b2, b3, smag, u, m, t, g, lim, kv;
      longint poly, s;
      bit sat, zero, sneg, gneg;
      logic [47:0] gout [3];
      o = '0;
      comp[0] = r.offset_x;
      comp[1] = r.offset_y;
      comp[2] = r.offset_z;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = comp[i][31];
         mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, comp[i]}) : {32'd0, comp[i]};
         sumsq = sumsq + mag[i] * mag[i];
      end
      norm = root_floor(sumsq);
      zero = (norm == 0);
      q = (norm * {32'd0, inv_h_reg}) >> FRAC_BITS;
      sat = 1'b0;
      poly = 0;
      s = 0;
      if (q < 2 * Q_ONE) begin
         a = 2 * Q_ONE - q;
         a2 = (a * a) >> FRAC_BITS;
         a3 = (a2 * a) >> FRAC_BITS;
         if (q < Q_ONE) begin
            b = Q_ONE - q;
            b2 = (b * b) >> FRAC_BITS;
            b3 = (b2 * b) >> FRAC_BITS;
            poly = longint'(a3) - 4 * longint'(b3);
            s = 12 * longint'(b2) - 3 * longint'(a2);
         end else begin
            poly = longint'(a3);
            s = -3 * longint'(a2);
         end
         if (poly < 0) poly = 0;
         kv = mul_frac_clip({16'd0, value_scale_reg}, poly, 64'hFFFF_FFFF_FFFF, sat);
         o.kernel_value = kv[47:0];
      end
      sneg = s < 0;
      smag = sneg ? -s : s;
      for (int i = 0; i < 3; i++) begin
         g = 0;
         gneg = sneg != neg[i];
         if (!zero && smag != 0) begin
            u = (mag[i] << FRAC_BITS) / norm;
            m = (smag * u) >> FRAC_BITS;
            t = (m * {32'd0, inv_h_reg}) >> FRAC_BITS;
            lim = gneg ? {16'd0, NEG_LIM} : {16'd0, POS_LIM};
            g = mul_frac_clip(t, {16'd0, grad_scale_reg}, lim, sat);
         end
         gout[i] = gneg ? (~g[47:0] + 48'd1) : g[47:0];
      end
      o.grad_x = gout[0];
      o.grad_y = gout[1];
      o.grad_z = gout[2];
      o.zero_distance = zero;
      o.saturated = sat;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      mismatches++;
      $display("Mismatch on %s at result %0d: got %h, expected %h",
               what, results_seen, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kernel_results_due.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.kernel_value, '0);
         end else begin
            want = kernel_results_due.pop_front();
            if (rsp_data.kernel_value !== want.kernel_value)
               report_mismatch("kernel_value", rsp_data.kernel_value, want.kernel_value);
            if (rsp_data.grad_x !== want.grad_x)
               report_mismatch("grad_x", rsp_data.grad_x, want.grad_x);
            if (rsp_data.grad_y !== want.grad_y)
               report_mismatch("grad_y", rsp_data.grad_y, want.grad_y);
            if (rsp_data.grad_z !== want.grad_z)
               report_mismatch("grad_z", rsp_data.grad_z, want.grad_z);
            if (rsp_data.zero_distance !== want.zero_distance)
               report_mismatch("zero_distance", 48'(rsp_data.zero_distance),
                               48'(want.zero_distance));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", 48'(rsp_data.saturated), 48'(want.saturated));
            zero_seen += want.zero_distance;
            sat_seen += want.saturated;
         end
         results_seen++;
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < LONG_HOLD; n++) @(posedge clock);
            hold_request = 1'b0;
         end else if (noisy && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_offset(input req_type item);
      if (noisy && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      kernel_results_due.push_back(kernel_of_offset(item));
      items_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [47:0] value);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INV_H:       inv_h_reg = value[31:0];
         CSR_VALUE_SCALE: value_scale_reg = value;
         CSR_GRAD_SCALE:  grad_scale_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (kernel_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type offset_of(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
      req_type r;
      r.offset_x = x;
      r.offset_y = y;
      r.offset_z = z;
      return r;
   endfunction

   function automatic logic [31:0] random_component();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0000_3000);
         default: v = $urandom_range(0, 32'h0002_4000);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic test_directed();
      send_offset(offset_of(0, 0, 0));
      send_offset(offset_of(32'h0001_0000, 0, 0));
      send_offset(offset_of(32'h0000_8000, 0, 0));
      send_offset(offset_of(32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_8000));
      send_offset(offset_of(0, 32'h0001_8000, 0));
      send_offset(offset_of(0, 0, 32'hFFFE_8000));
      send_offset(offset_of(32'h0002_0000, 0, 0));
      send_offset(offset_of(0, 32'h0001_FFFF, 0));
      send_offset(offset_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_offset(offset_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_offset(offset_of(32'h8000_0000, 32'h7FFF_FFFF, 0));
      send_offset(offset_of(1, 0, 0));
      send_offset(offset_of(0, 32'hFFFF_FFFF, 0));
      send_offset(offset_of(32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000));
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_register(CSR_SPARE, 48'hFFFF_FFFF_FFFF);
      write_register(CSR_VALUE_SCALE, 48'hFFFF_FFFF_FFFF);
      write_register(CSR_GRAD_SCALE, 48'hFFFF_FFFF_FFFF);
      write_register(CSR_INV_H, 48'h0000_0001_0000);
      for (int i = 0; i < 8; i++) send_offset(offset_of(random_component(),
                                              random_component(), random_component()));
      send_offset(offset_of(0, 0, 0));
      wait_idle();
      write_register(CSR_INV_H, 48'h0000_FFFF_FFFF);
      write_register(CSR_VALUE_SCALE, 48'd0);
      write_register(CSR_GRAD_SCALE, 48'd0);
      send_offset(offset_of(1, 0, 0));
      send_offset(offset_of(0, 0, 0));
      send_offset(offset_of(32'h7FFF_FFFF, 0, 0));
      wait_idle();
      write_register(CSR_INV_H, 48'd0);
      write_register(CSR_GRAD_SCALE, 48'd5215);
      send_offset(offset_of(32'h7FFF_FFFF, 32'h8000_0000, 1));
      send_offset(offset_of(0, 0, 0));
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 6; phase++) begin
         write_register(CSR_INV_H, (phase == 0) ? 48'h1_0000 :
                        {16'd0, 32'($urandom_range(32'h0000_4000, 32'h0004_0000))});
         write_register(CSR_VALUE_SCALE, (phase % 3 == 2) ? {$urandom, 16'($urandom)} :
                        48'($urandom_range(1, 32'h00FF_FFFF)));
         write_register(CSR_GRAD_SCALE, (phase % 3 == 1) ? {$urandom, 16'($urandom)} :
                        48'($urandom_range(1, 32'h00FF_FFFF)));
         for (int i = 0; i < 160; i++) begin
            if ($urandom_range(0, 40) == 0) send_offset(offset_of(0, 0, 0));
            else send_offset(offset_of(random_component(), random_component(),
                                       random_component()));
         end
         wait_idle();
      end
   endtask

   task automatic test_output_stall();
      write_register(CSR_INV_H, 48'h1_0000);
      write_register(CSR_VALUE_SCALE, 48'd5215);
      write_register(CSR_GRAD_SCALE, 48'd5215);
      hold_request = 1'b1;
      for (int i = 0; i < 150; i++)
         send_offset(offset_of(random_component(), random_component(), random_component()));
      wait_idle();
   endtask

   task automatic test_full_rate();
      noisy = 1'b0;
      for (int i = 0; i < 120; i++)
         send_offset(offset_of(random_component(), random_component(), random_component()));
      wait_idle();
   endtask

   initial begin
      inv_h_reg = INV_H_RESET;
      value_scale_reg = VALUE_SCALE_RESET;
      grad_scale_reg = GRAD_SCALE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_phases();
      test_output_stall();
      test_full_rate();
      $display("Covered %0d offsets and %0d results, %0d at zero distance, %0d clipped,",
               items_sent, results_seen, zero_seen, sat_seen);
      $display("over register extremes, random settings, a long output stall and full rate.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
